// ----- rtl/core/kts_pkg.sv -----
// package for the keyframe track sampler: payload structs, opcodes, controller links
// no dependencies
package kts_pkg;

  localparam int MaxKeys = 64;
  localparam int IdxW    = 6;
  localparam int CntW    = 7;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_LINEAR = 2'd2,
    FUNC_CUBIC  = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [31:0]        time_q;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
    logic signed [31:0] tin_x;
    logic signed [31:0] tin_y;
    logic signed [31:0] tin_z;
    logic signed [31:0] tout_x;
    logic signed [31:0] tout_y;
    logic signed [31:0] tout_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               valid_res;
    logic               accepted;
    logic [6:0]         key_count;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_LOAD    = 4'd1,  // latch item
    OP_RDTIME  = 4'd2,  // read time at address
    OP_CMPT    = 4'd3,  // compare read time to sample time
    OP_RDKEYS  = 4'd4,  // read key rows
    OP_DIVINIT = 4'd5,
    OP_DIVSTEP = 4'd6,
    OP_MUL     = 4'd7,  // one product of the serial multiply sequence
    OP_APPEND  = 4'd8,
    OP_CLEAR   = 4'd9,
    OP_RESP    = 4'd10
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [IdxW-1:0] addr;
    logic [4:0]      step;
    logic [1:0]      resp_kind;  // 0 op result, 1 zero-valid, 2 left value, 3 computed
    logic            resp_valid;
    logic            resp_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [CntW-1:0] count;
    logic            t_le;      // read time <= sample time
    logic            t_lt;      // read time < sample time
    logic            range_zero;
  } dp_stat_t;

  localparam logic [1:0] RespOp   = 2'd0;
  localparam logic [1:0] RespZero = 2'd1;
  localparam logic [1:0] RespLeft = 2'd2;
  localparam logic [1:0] RespCalc = 2'd3;

  // multiply sequence length: 2 (uu, uuu) + 8 steps per component
  localparam int MulSteps = 26;

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ----- rtl/core/kts_ctrl.sv -----
// controller for the keyframe track sampler: sequences search, divide and multiplies
// depends on kts_pkg
module kts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output kts_pkg::dp_cmd_t cmd,
  input  kts_pkg::dp_stat_t stat
);
  import kts_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DISP  = 10'b0000000010,
    S_TFST  = 10'b0000000100,
    S_TLST  = 10'b0000001000,
    S_SRCH  = 10'b0000010000,
    S_KEYS  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_RESP  = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [CntW-1:0] k, k_next;       // search index
  logic [IdxW-1:0] seg, seg_next;   // segment left index
  logic [4:0] cnt, cnt_next;
  logic       ph, ph_next;          // read phase: 0 compare, 1 decide and issue next read
  dp_cmd_t    c;

  assign busy = (state != S_IDLE);
  assign cmd  = c;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0; seg <= '0; cnt <= '0; ph <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next; seg <= seg_next; cnt <= cnt_next; ph <= ph_next;
    end
  end

  // next state and command
  always_comb begin
    state_next = state;
    k_next = k; seg_next = seg; cnt_next = cnt; ph_next = ph;
    c = '0;
    c.op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          c.op = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        ph_next = 1'b0;
        if (stat.func == FUNC_CLEAR) begin
          c.op = OP_CLEAR;
          state_next = S_RESP;
        end else if (stat.func == FUNC_APPEND) begin
          if (stat.count == '0 || stat.count == CntW'(MaxKeys)) begin
            c.op = OP_APPEND;  // datapath evaluates the rule
            state_next = S_RESP;
          end else begin
            c.op = OP_RDTIME;
            c.addr = IdxW'(stat.count - CntW'(1));
            state_next = S_TLST;
          end
        end else if (stat.count == '0) begin
          c.op = OP_RESP; c.resp_kind = RespZero;
          state_next = S_WAIT;
        end else begin
          c.op = OP_RDTIME; c.addr = '0;
          state_next = S_TFST;
        end
      end
      S_TFST: begin
        if (!ph) begin
          c.op = OP_CMPT; ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          if (stat.count == CntW'(1) || !stat.t_lt) begin
            seg_next = '0;
            c.op = OP_RDKEYS; c.addr = '0;
            cnt_next = 5'd1;
            state_next = S_KEYS;
          end else begin
            c.op = OP_RDTIME; c.addr = IdxW'(stat.count - CntW'(1));
            state_next = S_TLST;
          end
        end
      end
      S_TLST: begin
        if (!ph) begin
          c.op = OP_CMPT; ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          if (stat.func == FUNC_APPEND) begin
            c.op = OP_APPEND;
            state_next = S_RESP;
          end else if (stat.t_le) begin
            seg_next = IdxW'(stat.count - CntW'(1));
            c.op = OP_RDKEYS; c.addr = IdxW'(stat.count - CntW'(1));
            cnt_next = 5'd1;
            state_next = S_KEYS;
          end else begin
            seg_next = '0;
            k_next = CntW'(1);
            c.op = OP_RDTIME; c.addr = IdxW'(1);
            state_next = S_SRCH;
          end
        end
      end
      // walk keys 1..n-2; times rise, so the last key at or before t wins
      S_SRCH: begin
        if (!ph) begin
          c.op = OP_CMPT; ph_next = 1'b1;
        end else begin
          ph_next = 1'b0;
          if (stat.t_le) seg_next = k[IdxW-1:0];
          if (k + CntW'(2) < stat.count) begin
            k_next = k + CntW'(1);
            c.op = OP_RDTIME; c.addr = IdxW'(k + CntW'(1));
          end else begin
            c.op = OP_RDKEYS;
            c.addr = stat.t_le ? k[IdxW-1:0] : seg;
            cnt_next = 5'd0;
            state_next = S_KEYS;
          end
        end
      end
      // cnt=1: single row result (left value); cnt=0: right row lands; cnt=2: segment ready
      S_KEYS: begin
        if (cnt == 5'd1) begin
          c.op = OP_RESP; c.resp_kind = RespLeft; c.resp_valid = 1'b1;
          state_next = S_WAIT;
        end else if (cnt == 5'd0) begin
          cnt_next = 5'd2;
        end else if (stat.range_zero) begin
          c.op = OP_RESP; c.resp_kind = RespLeft; c.resp_valid = 1'b1;
          state_next = S_WAIT;
        end else begin
          c.op = OP_DIVINIT;
          cnt_next = 5'd0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        c.op = OP_DIVSTEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd15) begin
          cnt_next = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        c.op = OP_MUL; c.step = cnt;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(MulSteps - 1)) begin
          cnt_next = '0;
          state_next = S_RESP;
          c.resp_kind = RespCalc;
        end
      end
      S_RESP: begin
        c.op = OP_RESP;
        c.resp_kind = (stat.func[1]) ? RespCalc : RespOp;
        c.resp_valid = stat.func[1];
        state_next = S_IDLE;
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/kts_dpath.sv -----
// datapath for the keyframe track sampler: key memories, divider, multiplier, output
// depends on kts_pkg
module kts_dpath (
  input  logic              clk,
  input  logic              rst,
  input  kts_pkg::in_item_t item,
  input  kts_pkg::dp_cmd_t  cmd,
  output kts_pkg::dp_stat_t stat,
  output kts_pkg::out_item_t res,
  output logic              done
);
  import kts_pkg::*;

  // key memories
  logic [31:0]  mem_t [MaxKeys];
  logic [95:0]  mem_v [MaxKeys];
  logic [95:0]  mem_i [MaxKeys];
  logic [95:0]  mem_o [MaxKeys];

  in_item_t        it;
  logic [CntW-1:0] count;
  logic [31:0]     rd_t;
  logic [31:0]     t0, t1;
  logic [95:0]     v0, v1, ot0, it1;
  logic [IdxW-1:0] rd_row;
  logic            rd_pair;       // second row pending
  logic            t_le, t_lt;
  logic            rows_ok;
  logic            acc_flag;

  // divider
  logic [31:0] range;
  logic [48:0] rem;
  logic [15:0] quo;
  logic [48:0] num_sh;

  // multiplier sequencing
  logic [16:0] u, uu;
  logic signed [18:0] h1, h2, h3, h4;
  logic signed [47:0] m0, m1;
  logic signed [79:0] acc;
  logic signed [31:0] outv [3];

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mfull;

  logic [1:0] comp;
  logic [2:0] sub;

  // item latch, count and key writes
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.op == OP_CLEAR) count <= '0;
      if (cmd.op == OP_APPEND && count != CntW'(MaxKeys) &&
          (count == '0 || it.time_q > rd_t))
        count <= count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) it <= item;
    if (cmd.op == OP_APPEND && count != CntW'(MaxKeys) &&
        (count == '0 || it.time_q > rd_t)) begin
      mem_t[count[IdxW-1:0]] <= it.time_q;
      mem_v[count[IdxW-1:0]] <= {it.val_x, it.val_y, it.val_z};
      mem_i[count[IdxW-1:0]] <= {it.tin_x, it.tin_y, it.tin_z};
      mem_o[count[IdxW-1:0]] <= {it.tout_x, it.tout_y, it.tout_z};
    end
  end

  // time reads and compare
  always_ff @(posedge clk) begin
    if (cmd.op == OP_RDTIME) rd_t <= mem_t[cmd.addr];
    if (cmd.op == OP_CMPT) begin
      t_le <= rd_t <= it.time_q;
      t_lt <= rd_t <  it.time_q;
    end
  end

  // key row reads: left row at addr, right row at addr+1 next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pair <= 1'b0;
    end else begin
      rd_pair <= (cmd.op == OP_RDKEYS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RDKEYS) begin
      rd_row <= cmd.addr + IdxW'(1);
      t0  <= mem_t[cmd.addr];
      v0  <= mem_v[cmd.addr];
      ot0 <= mem_o[cmd.addr];
    end
    if (rd_pair) begin
      t1  <= mem_t[rd_row];
      v1  <= mem_v[rd_row];
      it1 <= mem_i[rd_row];
    end
  end
  assign rows_ok = 1'b1;

  // restoring divider, one quotient bit per step
  assign num_sh = {rem[47:0], 1'b0};
  always_ff @(posedge clk) begin
    if (cmd.op == OP_DIVINIT) begin
      range <= t1 - t0;
      rem   <= {17'd0, (it.time_q - t0)};
      quo   <= '0;
    end else if (cmd.op == OP_DIVSTEP) begin
      if (num_sh >= {17'd0, range}) begin
        rem <= num_sh - {17'd0, range};
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= num_sh;
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  // multiply step selection; wide tangent terms go in two halves
  always_comb begin
    comp = 2'd0;
    sub  = 3'd0;
    ma = '0;
    mb = '0;
    if (cmd.step >= 5'd2) begin
      comp = 2'((cmd.step - 5'd2) >> 3);
      sub  = 3'(cmd.step - 5'd2);
    end
    unique case (cmd.step)
      5'd0: begin ma = 33'(quo); mb = 33'(quo); end
      5'd1: begin ma = 33'(uu);  mb = 33'(u); end
      default: begin
        unique case (sub)
          3'd0: begin ma = 33'(signed'(ot0[95-32*comp -: 32])); mb = 33'(range); end
          3'd1: begin ma = 33'(signed'(it1[95-32*comp -: 32])); mb = 33'(range); end
          3'd2: begin
            if (it.func == FUNC_CUBIC) begin
              ma = 33'(signed'(v0[95-32*comp -: 32])); mb = 33'(h1);
            end else begin
              ma = 33'(signed'(v1[95-32*comp -: 32]))
                   - 33'(signed'(v0[95-32*comp -: 32]));
              mb = 33'(u);
            end
          end
          3'd3: begin ma = 33'(signed'(v1[95-32*comp -: 32])); mb = 33'(h2); end
          3'd4: begin ma = 33'(signed'(m0[47:24])); mb = 33'(h3); end
          3'd5: begin ma = 33'(m0[23:0]); mb = 33'(h3); end
          3'd6: begin ma = 33'(signed'(m1[47:24])); mb = 33'(h4); end
          3'd7: begin ma = 33'(m1[23:0]); mb = 33'(h4); end
        endcase
      end
    endcase
  end
  assign mfull = ma * mb;

  function automatic logic signed [79:0] fq16(input logic signed [65:0] v);
    return 80'(v >>> 16);
  endfunction

  // serial multiply and accumulate, one product per cycle
  always_ff @(posedge clk) begin
    if (cmd.op == OP_MUL) begin
      if (cmd.step == 5'd0) begin
        u  <= 17'(quo);
        uu <= 17'(mfull >>> 16);
      end else if (cmd.step == 5'd1) begin
        h1 <= 19'sd2 * signed'({2'b0, 17'(mfull >>> 16)}) - 19'sd3 * signed'({2'b0, uu})
              + 19'sd65536;
        h2 <= 19'sd3 * signed'({2'b0, uu}) - 19'sd2 * signed'({2'b0, 17'(mfull >>> 16)});
        h3 <= signed'({2'b0, 17'(mfull >>> 16)}) - 19'sd2 * signed'({2'b0, uu})
              + signed'({2'b0, u});
        h4 <= signed'({2'b0, 17'(mfull >>> 16)}) - signed'({2'b0, uu});
      end else begin
        unique case (sub)
          3'd0: m0 <= 48'(mfull >>> 16);
          3'd1: m1 <= 48'(mfull >>> 16);
          3'd2: begin
            if (it.func == FUNC_CUBIC) acc <= 80'(mfull);
            else outv[comp] <= sat32(80'(signed'(v0[95-32*comp -: 32])) + fq16(mfull));
          end
          3'd3: acc <= acc + 80'(mfull);
          3'd4: acc <= acc + (80'(mfull) <<< 24);
          3'd5: acc <= acc + 80'(mfull);
          3'd6: acc <= acc + (80'(mfull) <<< 24);
          3'd7: begin
            if (it.func == FUNC_CUBIC) outv[comp] <= sat32(80'((acc + 80'(mfull)) >>> 16));
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_RESP);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESP) begin
      res.valid_res <= cmd.resp_valid;
      res.key_count <= count;
      case (cmd.resp_kind)
        RespCalc: begin
          res.out_x <= cmd.resp_valid ? outv[0] : '0;
          res.out_y <= cmd.resp_valid ? outv[1] : '0;
          res.out_z <= cmd.resp_valid ? outv[2] : '0;
          res.accepted <= 1'b0;
        end
        RespLeft: begin
          res.out_x <= v0[95:64]; res.out_y <= v0[63:32]; res.out_z <= v0[31:0];
          res.accepted <= 1'b0;
        end
        RespZero: begin
          res.out_x <= '0; res.out_y <= '0; res.out_z <= '0;
          res.accepted <= 1'b0;
        end
        default: begin
          res.out_x <= '0; res.out_y <= '0; res.out_z <= '0;
          res.accepted <= acc_flag;
        end
      endcase
    end
  end

  // acceptance of the last clear or append
  always_ff @(posedge clk) begin
    if (rst) acc_flag <= 1'b0;
    else if (cmd.op == OP_CLEAR) acc_flag <= 1'b1;
    else if (cmd.op == OP_APPEND)
      acc_flag <= count != CntW'(MaxKeys) && (count == '0 || it.time_q > rd_t);
  end

  assign stat.func = it.func;
  assign stat.count = count;
  assign stat.t_le = t_le;
  assign stat.t_lt = t_lt;
  assign stat.range_zero = (t1 == t0) && rows_ok;
endmodule

// ----- rtl/core/keyframe_track_sampler_unit.sv -----
// top level of the keyframe track sampler: controller plus datapath
// depends on kts_pkg, kts_ctrl, kts_dpath
//
// channel   ports                      handshake
// input     start, busy, in_item       taken when start && !busy
// result    strobe, out_item           one cycle, no back-pressure
//
// append reads and compares the last key time unless the track is empty or full
// an empty track samples to zeros; a clamped sample (at or before the first key, or
// at or after the last key) returns that key's value; a sample inside the track walks
// the inner keys, then runs the restoring divider and the serial multiply sequence
// synchronous reset empties the track; key memories are not cleared
// results cannot be stalled; the next transfer is taken once busy falls
module keyframe_track_sampler_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  kts_pkg::in_item_t   in_item,
  output logic                strobe,
  output kts_pkg::out_item_t  out_item
);
  import kts_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  kts_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .stat (stat)
  );

  kts_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .item(in_item),
    .cmd (cmd),
    .stat(stat),
    .res (out_item),
    .done(strobe)
  );

  // the key count never exceeds the store depth
  assert property (@(posedge clk) disable iff (rst)
    out_item.key_count <= CntW'(MaxKeys) || !strobe)
    else $error("key count overflow");
  // results only appear while an item is in flight
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result without item");
  // a result never comes with an accepted sample
  assert property (@(posedge clk) disable iff (rst)
    strobe && out_item.valid_res |-> !out_item.accepted)
    else $error("sample marked accepted");
endmodule
